// File: src/okbs_pkg.sv
// Shared types, register codes and helpers for the offset keyed byte scrambler.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package okbs_pkg;

    localparam int unsigned KeyBits     = 128;
    localparam int unsigned RotBits     = 7;    // log2(KeyBits)
    localparam int unsigned CfgIdxBits  = 3;
    localparam int unsigned CfgDataBits = 64;

    // Register codes of the configuration port
    typedef enum logic [CfgIdxBits-1:0] {
        CFG_PRIV_HI  = 3'd0,
        CFG_PRIV_LO  = 3'd1,
        CFG_PUB_HI   = 3'd2,
        CFG_PUB_LO   = 3'd3,
        CFG_DECRYPT  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  data_in;
        logic [62:0] file_offset;
        logic        last_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } t_out_item;

    typedef struct packed {
        logic [KeyBits-1:0] priv_key;
        logic [KeyBits-1:0] pub_key;
        logic               decrypt;
    } t_cfg;

    // Exchange each pair of adjacent bits
    function automatic logic [7:0] swap_pairs(input logic [7:0] x);
        return ((x & 8'h55) << 1) | ((x & 8'hAA) >> 1);
    endfunction

endpackage

`default_nettype wire

// File: src/okbs_cfg_regs.sv
// Configuration register file: both 128-bit keys and the mode bit.
// Depends on okbs_pkg.
`default_nettype none

module okbs_cfg_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    input  wire logic [okbs_pkg::CfgIdxBits-1:0]     i_cfg_index,
    input  wire logic [okbs_pkg::CfgDataBits-1:0]    i_cfg_data,
    output okbs_pkg::t_cfg                           o_cfg
);

    okbs_pkg::t_cfg r_cfg;
    okbs_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (okbs_pkg::t_cfg_idx'(i_cfg_index))
                okbs_pkg::CFG_PRIV_HI: n_cfg.priv_key[127:64] = i_cfg_data;
                okbs_pkg::CFG_PRIV_LO: n_cfg.priv_key[63:0]   = i_cfg_data;
                okbs_pkg::CFG_PUB_HI:  n_cfg.pub_key[127:64]  = i_cfg_data;
                okbs_pkg::CFG_PUB_LO:  n_cfg.pub_key[63:0]    = i_cfg_data;
                okbs_pkg::CFG_DECRYPT: n_cfg.decrypt          = i_cfg_data[0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: src/okbs_key_byte.sv
// Picks one byte of a 128-bit key rotated left by a 7-bit amount.
// Depends on okbs_pkg.
`default_nettype none

module okbs_key_byte (
    input  wire logic [okbs_pkg::KeyBits-1:0] i_key,
    input  wire logic [okbs_pkg::RotBits-1:0] i_rot,
    input  wire logic [3:0]                   i_sel,
    output logic [7:0]                        o_byte
);

    logic [okbs_pkg::RotBits-1:0]   pos;
    logic [okbs_pkg::RotBits-1:0]   src;
    logic [2*okbs_pkg::KeyBits-1:0] key_twice;

    // Word sel[3:2] counts from the top, byte sel[1:0] from the bottom of that word
    assign pos       = {~i_sel[3:2], i_sel[1:0], 3'b000};
    // Rotating left by r moves source bit (pos - r) to pos
    assign src       = pos - i_rot;
    assign key_twice = {i_key, i_key};
    assign o_byte    = key_twice[src +: 8];

endmodule

`default_nettype wire

// File: src/offset_keyed_byte_scrambler.sv
// Top level of the offset keyed byte scrambler: input register, key byte
// selection, transform and result register. Depends on okbs_pkg,
// okbs_cfg_regs and okbs_key_byte.
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+--------------------------
//  command   | in        | start, busy                 | i_item (okbs_pkg::t_in_item)
//  result    | out       | o_valid (one-cycle strobe)  | o_result (t_out_item)
//  config    | in        | i_cfg_valid, o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One item is taken every cycle while busy is low; each passes the input register and
// then the result register before its result strobes out.
// Reset is synchronous, active low; it clears the keys, the mode bit and the
// pipeline valid bits, and busy is high while reset is held.
// The receiver cannot stall, so busy is low whenever reset is released.
`default_nettype none

module offset_keyed_byte_scrambler (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire okbs_pkg::t_in_item                  i_item,
    output logic                                     o_valid,
    output okbs_pkg::t_out_item                      o_result,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [okbs_pkg::CfgIdxBits-1:0]     i_cfg_index,
    input  wire logic [okbs_pkg::CfgDataBits-1:0]    i_cfg_data
);

    okbs_pkg::t_cfg      cfg;
    okbs_pkg::t_in_item  r_in;
    logic                r_in_valid;
    okbs_pkg::t_out_item r_out;
    okbs_pkg::t_out_item n_out;
    logic                r_out_valid;
    logic                accept;

    logic [okbs_pkg::RotBits-1:0] rot_priv;
    logic [okbs_pkg::RotBits-1:0] rot_pub;
    logic [7:0]                   k_priv;
    logic [7:0]                   k_pub;

    assign busy        = !i_rst_n;
    assign accept      = start && !busy;
    assign o_cfg_ready = i_rst_n;

    okbs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= accept;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
        r_out <= n_out;
    end

    // Block number mod 128 is offset bits 10:4, segment number mod 128 bits 17:11
    assign rot_priv = r_in.file_offset[10:4] + 7'd1;
    assign rot_pub  = r_in.file_offset[17:11] + 7'd1;

    okbs_key_byte u_priv_byte (
        .i_key  (cfg.priv_key),
        .i_rot  (rot_priv),
        .i_sel  (r_in.file_offset[3:0]),
        .o_byte (k_priv)
    );

    okbs_key_byte u_pub_byte (
        .i_key  (cfg.pub_key),
        .i_rot  (rot_pub),
        .i_sel  (r_in.file_offset[3:0]),
        .o_byte (k_pub)
    );

    always_comb begin
        if (cfg.decrypt) begin
            n_out.data_out = okbs_pkg::swap_pairs(r_in.data_in ^ k_priv) ^ k_pub;
        end else begin
            n_out.data_out = okbs_pkg::swap_pairs(r_in.data_in ^ k_pub) ^ k_priv;
        end
        n_out.last_out = r_in.last_in;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Every accepted item strobes out after passing the input and result registers
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_valid)
        else $error("accepted item produced no result");

    a_result_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 2))
        else $error("result strobe without an accepted item");

    a_last_passed_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.last_out == $past(i_item.last_in, 2))
        else $error("last marker not carried with its item");

    // With both keys clear and stable, the transform reduces to the pair swap
    a_zero_key_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && cfg.priv_key == '0 && cfg.pub_key == '0 && $stable(cfg))
        |-> o_result.data_out == okbs_pkg::swap_pairs($past(i_item.data_in, 2)))
        else $error("zero key result is not the pair swap of the input");

endmodule

`default_nettype wire

// File: sim/okbs_checker.sv
// Scoreboard for the offset keyed byte scrambler: watches the command, config and result
// channels, predicts each result and compares it with what the block strobes out.
// Depends on okbs_pkg for the item types and register codes.
`default_nettype none

module okbs_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_busy,
    input  wire okbs_pkg::t_in_item            i_item,
    input  wire logic                          i_res_valid,
    input  wire okbs_pkg::t_out_item           i_result,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [okbs_pkg::CfgIdxBits-1:0]  i_cfg_index,
    input  wire logic [okbs_pkg::CfgDataBits-1:0] i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import okbs_pkg::*;

    logic [KeyBits-1:0] priv_key;
    logic [KeyBits-1:0] pub_key;
    logic               decrypt_on;
    t_out_item          scrambled_q[$];
    t_out_item          want;
    int                 fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Rotate the key left by rot and take byte sel; byte 0 is the low byte of the top word.
    function automatic logic [7:0] pick_key_byte(input logic [KeyBits-1:0] key,
                                                 input logic [RotBits-1:0] rot,
                                                 input logic [3:0] sel);
        logic [KeyBits-1:0] turned;
        int unsigned        base;
        turned = (key << rot) | (key >> (KeyBits - int'(rot)));
        base   = 96 - 32 * int'(sel[3:2]) + 8 * int'(sel[1:0]);
        return turned[base +: 8];
    endfunction

    function automatic logic [7:0] swap_bit_pairs(input logic [7:0] x);
        logic [7:0] y;
        for (int i = 0; i < 4; i++) begin
            y[2*i]   = x[2*i+1];
            y[2*i+1] = x[2*i];
        end
        return y;
    endfunction

    function automatic t_out_item scramble_byte(input t_in_item it);
        t_out_item        res;
        logic [RotBits-1:0] rot_priv;
        logic [RotBits-1:0] rot_pub;
        logic [7:0]       k_priv;
        logic [7:0]       k_pub;
        // block number is offset/16, segment number offset/2048; both wrap mod 128
        rot_priv = it.file_offset[10:4] + 7'd1;
        rot_pub  = it.file_offset[17:11] + 7'd1;
        k_priv   = pick_key_byte(priv_key, rot_priv, it.file_offset[3:0]);
        k_pub    = pick_key_byte(pub_key, rot_pub, it.file_offset[3:0]);
        if (decrypt_on) begin
            res.data_out = swap_bit_pairs(it.data_in ^ k_priv) ^ k_pub;
        end else begin
            res.data_out = swap_bit_pairs(it.data_in ^ k_pub) ^ k_priv;
        end
        res.last_out = it.last_in;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            priv_key   = '0;
            pub_key    = '0;
            decrypt_on = 1'b0;
            scrambled_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PRIV_HI: priv_key[127:64] = i_cfg_data;
                    CFG_PRIV_LO: priv_key[63:0]   = i_cfg_data;
                    CFG_PUB_HI:  pub_key[127:64]  = i_cfg_data;
                    CFG_PUB_LO:  pub_key[63:0]    = i_cfg_data;
                    CFG_DECRYPT: decrypt_on       = i_cfg_data[0];
                    default: ;  // drop writes to unknown registers
                endcase
            end
            if (i_res_valid) begin
                if (scrambled_q.size() == 0) begin
                    $display("%0t: unexpected result data_out %02h last_out %0b",
                             $time, i_result.data_out, i_result.last_out);
                    fails++;
                end else begin
                    want = scrambled_q.pop_front();
                    if (i_result.data_out !== want.data_out) begin
                        $display("%0t: data_out expected %02h actual %02h",
                                 $time, want.data_out, i_result.data_out);
                        fails++;
                    end
                    if (i_result.last_out !== want.last_out) begin
                        $display("%0t: last_out expected %0b actual %0b",
                                 $time, want.last_out, i_result.last_out);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                scrambled_q.push_back(scramble_byte(i_item));
            end
        end
        o_fail_count <= fails;
        o_pending    <= scrambled_q.size();
    end

endmodule

`default_nettype wire

// File: sim/offset_keyed_byte_scrambler_tb.sv
// Stimulus and verdict for the offset keyed byte scrambler: directed edge offsets, then
// streamed buffers and loose bytes under several key settings. Depends on okbs_pkg,
// okbs_checker and the block itself.
`default_nettype none

module offset_keyed_byte_scrambler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import okbs_pkg::*;

    localparam int unsigned StallLimit    = 4000;
    localparam int unsigned SettleCycles  = 4;
    localparam int unsigned DrainCycles   = 8;
    localparam int unsigned RandomPhases  = 7;
    localparam int unsigned ItemsPerPhase = 215;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic                   busy;
    t_in_item               i_item      = '0;
    logic                   o_valid;
    t_out_item              o_result;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CfgIdxBits-1:0]  cfg_index   = '0;
    logic [CfgDataBits-1:0] cfg_data    = '0;
    int                     fail_count;
    int                     pending;
    int unsigned            stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    offset_keyed_byte_scrambler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    okbs_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_res_valid  (o_valid),
        .i_result     (o_result),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    function automatic logic [63:0] pick_key_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic push_byte(input t_in_item it, input int unsigned gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [63:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
    endtask

    // Let the pipe drain, then load a whole key setting plus one write to a bogus index.
    task automatic load_keys(input logic [63:0] priv_hi, input logic [63:0] priv_lo,
                             input logic [63:0] pub_hi, input logic [63:0] pub_lo,
                             input logic dec);
        logic [CfgIdxBits-1:0] bad_idx;
        logic [63:0]           mode_word;
        start = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        @(negedge i_clk);
        bad_idx      = CfgIdxBits'(int'(CFG_DECRYPT) + int'($urandom_range(1, 3)));
        mode_word    = {$urandom, $urandom};
        mode_word[0] = dec;
        write_reg(CFG_PRIV_HI, priv_hi);
        write_reg(CFG_PRIV_LO, priv_lo);
        write_reg(bad_idx, {$urandom, $urandom});
        write_reg(CFG_PUB_HI, pub_hi);
        write_reg(CFG_PUB_LO, pub_lo);
        write_reg(CFG_DECRYPT, mode_word);
        cfg_valid = 1'b0;
    endtask

    initial begin
        logic [62:0]  edge_offs[$];
        logic [7:0]   edge_bytes[$];
        t_in_item     it;
        int unsigned  sent;
        int unsigned  len;
        int unsigned  r;
        logic [62:0]  base;
        bit           burst;

        edge_offs  = '{63'd0, 63'd15, 63'd16, 63'd2031, 63'd2032, 63'd2047, 63'd2048,
                       63'd260101, 63'h4000_0000_0000_0000, 63'h7FFF_FFFF_FFFF_FFF0,
                       63'h7FFF_FFFF_FFFF_FFFF};
        edge_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset keys are zero: output is just the pair swap
        for (int i = 0; i < 4; i++) begin
            it.data_in     = edge_bytes[i];
            it.file_offset = edge_offs[i * 3];
            it.last_in     = i[0];
            push_byte(it, 0);
        end

        // edge offsets: rotation wrap at block 127 and segment 127, top of offset range
        for (int m = 0; m < 2; m++) begin
            load_keys(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                      64'hA5C3_0F96_5A3C_F069, 64'h8000_0000_0000_0001, m[0]);
            for (int i = 0; i < edge_offs.size(); i++) begin
                it.data_in     = edge_bytes[i % 4];
                it.file_offset = edge_offs[i];
                it.last_in     = (i % 3) == 2;
                push_byte(it, 0);
            end
        end

        for (int ph = 0; ph < RandomPhases; ph++) begin
            case (ph)
                0: load_keys('0, '0, '0, '0, 1'b1);
                1: load_keys('1, '1, '1, '1, 1'b0);
                2: load_keys('1, '0, '0, '1, 1'b1);
                default: load_keys(pick_key_word(), pick_key_word(), pick_key_word(),
                                   pick_key_word(), 1'($urandom));
            endcase
            sent = 0;
            while (sent < ItemsPerPhase) begin
                if ($urandom_range(0, 3) != 0) begin
                    // a buffer streamed from some file position, last on its final byte
                    len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 48)
                                                       : $urandom_range(49, 320);
                    // keep the phase to its item budget
                    if (len > ItemsPerPhase - sent) begin
                        len = ItemsPerPhase - sent;
                    end
                    r = $urandom_range(0, 99);
                    if (r < 40) begin
                        base = 63'($urandom_range(0, 8191));
                    end else if (r < 70) begin
                        base = 63'({$urandom, $urandom});
                    end else if (r < 85) begin
                        base = 63'($urandom_range(1, 300)) * 63'd2048 - 63'($urandom_range(0, 40));
                    end else begin
                        base = 63'h7FFF_FFFF_FFFF_FFFF - 63'($urandom_range(0, 400));
                    end
                    burst = $urandom_range(0, 3) == 0;
                    for (int unsigned i = 0; i < len; i++) begin
                        it.data_in     = 8'($urandom);
                        it.file_offset = base + 63'(i);
                        it.last_in     = (i == len - 1);
                        push_byte(it, burst ? 0 : pick_gap());
                        sent++;
                    end
                end else begin
                    it.data_in     = 8'($urandom);
                    it.file_offset = 63'({$urandom, $urandom});
                    it.last_in     = 1'($urandom);
                    push_byte(it, pick_gap());
                    sent++;
                end
            end
        end

        start = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
